### rtl/core/sal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sal_pkg
// Shared types and codes of the sorted array list engine.
// ----------------------------------------------------------------------------
package sal_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ActionW = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 7;

  typedef enum logic [ActionW-1:0] {
    ACT_ORD_INS   = 3'd0,
    ACT_HEAD_INS  = 3'd1,
    ACT_SEARCH    = 3'd2,
    ACT_DEL_FIRST = 3'd3,
    ACT_DEL_ALL   = 3'd4
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // flags from the shared compare unit
  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_t;

endpackage

### rtl/core/sorted_array_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_array_list_engine
// Bounded list of signed 32-bit values held in a RAM, with ordered insert,
// head insert, search, delete first match and delete all matches.
//
//   channel   signals                                         dir
//   request   start, busy, action_i, value_i                  in
//   result    done_o, status_o, found_o, entry_count_o,       out
//             removed_count_o
//
// A request is taken when start is high and busy is low. Each insert,
// search or delete walks the stored entries one RAM read per cycle through
// the single read port; a full-list insert or an unused action does no walk
// and goes straight to the result.
// done_o is high for one cycle with the result; the receiver cannot stall.
// Reset clears the state, count, pending flag and result registers; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module sorted_array_list_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [sal_pkg::ActionW-1:0] action_i,
  input  logic signed [sal_pkg::DataW-1:0] value_i,
  output logic                        done_o,
  output logic [sal_pkg::StatusW-1:0] status_o,
  output logic                        found_o,
  output logic [sal_pkg::CountW-1:0]  entry_count_o,
  output logic [sal_pkg::CountW-1:0]  removed_count_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [CW-1:0] OneC   = CW'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN_UP,
    S_SCAN_DN,
    S_RESP
  } state_e;

  state_e                      state_q, state_d;
  logic [sal_pkg::ActionW-1:0] action_q, action_d;
  logic [sal_pkg::DataW-1:0]   value_q, value_d;
  logic [CW-1:0]               count_q, count_d;
  logic [CW-1:0]               rd_idx_q, rd_idx_d;
  logic [CW-1:0]               wr_idx_q, wr_idx_d;
  logic [CW-1:0]               pend_idx_q, pend_idx_d;
  logic                        pend_q, pend_d;
  logic [CW-1:0]               removed_q, removed_d;
  sal_pkg::status_e            status_q, status_d;
  logic                        found_q, found_d;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [sal_pkg::DataW-1:0]   ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [sal_pkg::DataW-1:0]   ram_rdata;
  sal_pkg::cmp_t               cmp;

  logic [CW-1:0]               rd_prev;
  logic [CW-1:0]               pend_next;
  logic                        hit;

  sal_ram #(
    .WIDTH (sal_pkg::DataW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sal_cmp u_cmp (
    .entry_i (ram_rdata),
    .value_i (value_q),
    .res_o   (cmp)
  );

  assign rd_prev   = rd_idx_q - OneC;
  assign pend_next = pend_idx_q + OneC;
  // a counted match: every match for delete all, else only the first; deletes drop it
  assign hit = cmp.eq &&
               ((action_q == sal_pkg::ACT_DEL_ALL) || (removed_q == '0));

  always_comb begin
    state_d    = state_q;
    action_d   = action_q;
    value_d    = value_q;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    wr_idx_d   = wr_idx_q;
    pend_idx_d = pend_idx_q;
    pend_d     = 1'b0;
    removed_d  = removed_q;
    status_d   = status_q;
    found_d    = found_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = value_q;
    ram_re     = 1'b0;
    ram_raddr  = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          action_d  = action_i;
          value_d   = value_i;
          removed_d = '0;
          found_d   = 1'b0;
          wr_idx_d  = '0;
          status_d  = sal_pkg::ST_DONE;
          case (action_i)
            sal_pkg::ACT_ORD_INS, sal_pkg::ACT_HEAD_INS: begin
              if (count_q >= DepthC) begin
                status_d = sal_pkg::ST_FULL;
                state_d  = S_RESP;
              end else begin
                rd_idx_d = count_q;
                state_d  = S_SCAN_DN;
              end
            end
            sal_pkg::ACT_SEARCH, sal_pkg::ACT_DEL_FIRST, sal_pkg::ACT_DEL_ALL: begin
              rd_idx_d = '0;
              state_d  = S_SCAN_UP;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_SCAN_DN: begin
        // read one below the top while the previous word moves up
        if (rd_idx_q != '0) begin
          ram_re     = 1'b1;
          ram_raddr  = rd_prev[AW-1:0];
          pend_d     = 1'b1;
          pend_idx_d = rd_prev;
          rd_idx_d   = rd_prev;
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_next[AW-1:0];
          if ((action_q == sal_pkg::ACT_HEAD_INS) || cmp.gt) begin
            ram_wdata = ram_rdata;
          end else begin
            ram_wdata = value_q;
            count_d   = count_q + OneC;
            pend_d    = 1'b0;
            state_d   = S_RESP;
          end
        end else if (rd_idx_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = value_q;
          count_d   = count_q + OneC;
          state_d   = S_RESP;
        end
      end

      S_SCAN_UP: begin
        if (rd_idx_q != count_q) begin
          ram_re    = 1'b1;
          ram_raddr = rd_idx_q[AW-1:0];
          pend_d    = 1'b1;
          rd_idx_d  = rd_idx_q + OneC;
        end
        if (pend_q) begin
          if (hit) begin
            removed_d = removed_q + OneC;
          end else if (action_q != sal_pkg::ACT_SEARCH) begin
            // compaction: kept words close up behind the removed ones
            ram_we    = 1'b1;
            ram_waddr = wr_idx_q[AW-1:0];
            ram_wdata = ram_rdata;
            wr_idx_d  = wr_idx_q + OneC;
          end
        end else if (rd_idx_q == count_q) begin
          if (removed_q == '0) begin
            status_d = sal_pkg::ST_NOT_FOUND;
            found_d  = 1'b0;
          end else begin
            status_d = sal_pkg::ST_DONE;
            found_d  = 1'b1;
          end
          if (action_q == sal_pkg::ACT_SEARCH) begin
            removed_d = '0;
          end else begin
            count_d = count_q - removed_q;
          end
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      pend_q    <= 1'b0;
      removed_q <= '0;
      status_q  <= sal_pkg::ST_DONE;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
      removed_q <= removed_d;
      status_q  <= status_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q   <= action_d;
    value_q    <= value_d;
    rd_idx_q   <= rd_idx_d;
    wr_idx_q   <= wr_idx_d;
    pend_idx_q <= pend_idx_d;
  end

  assign busy            = state_q != S_IDLE;
  assign done_o          = state_q == S_RESP;
  assign status_o        = status_q;
  assign found_o         = found_q;
  assign entry_count_o   = sal_pkg::CountW'(count_q);
  assign removed_count_o = sal_pkg::CountW'(removed_q);

endmodule

### rtl/core/sal_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sal_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sal_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sal_cmp
// Shared compare unit: signed greater-than and equality of a stored entry
// against the request value.
// ----------------------------------------------------------------------------
module sal_cmp (
  input  logic [sal_pkg::DataW-1:0] entry_i,
  input  logic [sal_pkg::DataW-1:0] value_i,
  output sal_pkg::cmp_t             res_o
);

  always_comb begin
    res_o.gt = $signed(entry_i) > $signed(value_i);
    res_o.eq = entry_i == value_i;
  end

endmodule
